FILE: rtl/core/afdtd_pkg.sv
// shared types, codes and fixed widths for the acoustic fdtd step block
// no dependencies; used by every module under rtl/core except afdtd_ram
package afdtd_pkg;

  // counter and grid widths
  localparam int CNT_W  = 8;   // cell counters, enough for 256 columns or rows
  localparam int GRID_W = 7;   // configured grid size, at most 63 + 15 + 15 + 2

  // arithmetic widths
  localparam int DIFF_W = 35;  // stencil difference, up to four q16.16 terms
  localparam int ACC_W  = 68;  // full product of difference and coefficient
  localparam int SUM_W  = 49;  // old value minus scaled product
  localparam int X_W    = 35;  // clipped pre-damping value
  localparam int K_W    = 5;   // depth into the absorbing layer
  localparam int M_W    = 5;   // damping numerator 2L
  localparam int DND_W  = 39;  // divider dividend
  localparam int DVS_W  = 6;   // divider divisor 2L + k
  localparam int LO_W   = 18;  // low slice of the difference in the split product
  localparam int FRAC_W = 20;  // coefficient fraction bits

  // pre-damping clip, damping never shrinks by more than a third
  localparam logic signed [SUM_W-1:0] X_LIMIT = 49'sd8589934592;

  // four fifths of the column count through a reciprocal
  localparam int SKIP_MUL   = 205;
  localparam int SKIP_SHIFT = 10;

  // actions
  localparam logic [1:0] ACT_STEP  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MAIN_COLS  = 3'd0;
  localparam logic [2:0] CFG_MAIN_ROWS  = 3'd1;
  localparam logic [2:0] CFG_PML_LAYERS = 3'd2;
  localparam logic [2:0] CFG_PML_EDGES  = 3'd3;
  localparam logic [2:0] CFG_VEL_COEF   = 3'd4;
  localparam logic [2:0] CFG_PRS_COEF   = 3'd5;

  // configuration reset values
  localparam logic [5:0]  RST_MAIN_COLS  = 6'd40;
  localparam logic [5:0]  RST_MAIN_ROWS  = 6'd40;
  localparam logic [3:0]  RST_PML_LAYERS = 4'd6;
  localparam logic [3:0]  RST_PML_EDGES  = 4'd15;
  localparam logic [31:0] RST_VEL_COEF   = 32'd1828;
  localparam logic [31:0] RST_PRS_COEF   = 32'd289198309;

  // edge enable bits
  localparam int EDGE_UP    = 0;
  localparam int EDGE_DOWN  = 1;
  localparam int EDGE_LEFT  = 2;
  localparam int EDGE_RIGHT = 3;

  // read address phases
  localparam logic [1:0] RD_CENTER = 2'd0;
  localparam logic [1:0] RD_NEAR   = 2'd1;  // p left, vx right, vy below
  localparam logic [1:0] RD_FAR    = 2'd2;  // p above

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_MLO   = 3'd2;
  localparam logic [2:0] OP_MHI   = 3'd3;
  localparam logic [2:0] OP_SUB   = 3'd4;
  localparam logic [2:0] OP_SCALE = 3'd5;
  localparam logic [2:0] OP_SAT   = 3'd6;

  // updated field
  localparam logic [1:0] SEL_VX = 2'd0;
  localparam logic [1:0] SEL_VY = 2'd1;
  localparam logic [1:0] SEL_P  = 2'd2;

  // write data source
  localparam logic [1:0] WS_RES  = 2'd0;
  localparam logic [1:0] WS_IN   = 2'd1;
  localparam logic [1:0] WS_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         cell_col;
    logic [5:0]         cell_row;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             rd_en;
    logic [1:0]       rd_phase;
    logic             cap_center;
    logic             cap_near;
    logic             cap_far;
    logic [2:0]       op;
    logic [1:0]       sel;
    logic             div_start;
    logic             wr_p;
    logic             wr_vx;
    logic             wr_vy;
    logic [1:0]       wr_src;
    logic             take_in;
    logic             out_load;
    logic             out_rd;
    logic [1:0]       out_status;
  } cmd_t;

  typedef struct packed {
    logic              oversize;
    logic [GRID_W-1:0] cols;
    logic [GRID_W-1:0] rows;
    logic [GRID_W-1:0] skip_lim;
    logic              div_busy;
  } sts_t;

endpackage

FILE: rtl/core/acoustic_fdtd2d_pml_step.sv
// top level of the two-dimensional acoustic fdtd step block with absorbing edges
// depends on afdtd_pkg, afdtd_ctrl and afdtd_datapath (with afdtd_ram, afdtd_div)

// Keeps pressure, x-velocity and y-velocity grids of MAX_COLS x MAX_ROWS signed
// q16.16 words in three single-port-read rams, one transaction in flight at a time.
// After reset a clearing sweep zeroes all three stores, one entry per cycle; no
// input is taken meanwhile, configuration writes are. A step transaction runs a
// velocity pass and then a pressure pass over the interior cells; the velocity
// pass skips the first interior row left of four fifths of the width. Each update
// goes through the shared 18/17-by-32 split multiply and the one-bit-per-cycle
// damping divider. A velocity cell takes two updates, a pressure cell one.
// An oversized configured grid, or an address outside the grid, answers at once
// with an error status. The user is to write configuration only while the block
// is idle; the block itself does not enforce it.
module acoustic_fdtd2d_pml_step #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input transactions
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  afdtd_pkg::in_item_t  in_data_i,
  // result transactions
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output afdtd_pkg::out_item_t out_data_o,
  // configuration writes, always taken
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  afdtd_pkg::cmd_t cmd;
  afdtd_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencing of clear sweep, decode and cell loops
  afdtd_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  // stores, configuration and update arithmetic
  afdtd_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_datapath (
    .clk_i,
    .rst_ni,
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .in_data_i,
    .cmd_i(cmd),
    .sts_o(sts),
    .out_data_o
  );

endmodule

FILE: rtl/core/afdtd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module afdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/afdtd_div.sv
// restoring divider, one quotient bit per cycle
// depends on afdtd_pkg for the dividend and divisor widths
module afdtd_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [afdtd_pkg::DND_W-1:0]      dividend_i,
  input  logic [afdtd_pkg::DVS_W-1:0]      divisor_i,
  output logic                             busy_o,
  output logic [afdtd_pkg::DND_W-1:0]      quotient_o
);

  localparam int DND_W = afdtd_pkg::DND_W;
  localparam int DVS_W = afdtd_pkg::DVS_W;
  localparam int CW    = $clog2(DND_W + 1);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DND_W-1:0] quo_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DND_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DND_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[DND_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/core/afdtd_datapath.sv
// datapath: configuration registers, grid stores, stencil update arithmetic
// depends on afdtd_pkg, afdtd_ram and afdtd_div
module afdtd_datapath #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  afdtd_pkg::in_item_t  in_data_i,
  input  afdtd_pkg::cmd_t      cmd_i,
  output afdtd_pkg::sts_t      sts_o,
  output afdtd_pkg::out_item_t out_data_o
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int GRID_W = afdtd_pkg::GRID_W;
  localparam int DIFF_W = afdtd_pkg::DIFF_W;
  localparam int ACC_W  = afdtd_pkg::ACC_W;
  localparam int SUM_W  = afdtd_pkg::SUM_W;
  localparam int X_W    = afdtd_pkg::X_W;
  localparam int K_W    = afdtd_pkg::K_W;
  localparam int M_W    = afdtd_pkg::M_W;
  localparam int DND_W  = afdtd_pkg::DND_W;
  localparam int DVS_W  = afdtd_pkg::DVS_W;
  localparam int LO_W   = afdtd_pkg::LO_W;
  localparam int HI_W   = DIFF_W - LO_W;

  // configuration
  logic [5:0]  main_cols_q, main_rows_q;
  logic [3:0]  layers_q, edges_q;
  logic [31:0] vcoef_q, pcoef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_cols_q <= afdtd_pkg::RST_MAIN_COLS;
      main_rows_q <= afdtd_pkg::RST_MAIN_ROWS;
      layers_q    <= afdtd_pkg::RST_PML_LAYERS;
      edges_q     <= afdtd_pkg::RST_PML_EDGES;
      vcoef_q     <= afdtd_pkg::RST_VEL_COEF;
      pcoef_q     <= afdtd_pkg::RST_PRS_COEF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        afdtd_pkg::CFG_MAIN_COLS:  main_cols_q <= cfg_data_i[5:0];
        afdtd_pkg::CFG_MAIN_ROWS:  main_rows_q <= cfg_data_i[5:0];
        afdtd_pkg::CFG_PML_LAYERS: layers_q    <= cfg_data_i[3:0];
        afdtd_pkg::CFG_PML_EDGES:  edges_q     <= cfg_data_i[3:0];
        afdtd_pkg::CFG_VEL_COEF:   vcoef_q     <= cfg_data_i;
        afdtd_pkg::CFG_PRS_COEF:   pcoef_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // grid geometry
  logic [GRID_W-1:0] lay, lay_l, lay_r, lay_u, lay_d, cols, rows;
  logic [16:0]       skip_prod;

  assign lay   = GRID_W'(layers_q);
  assign lay_l = edges_q[afdtd_pkg::EDGE_LEFT]  ? lay : '0;
  assign lay_r = edges_q[afdtd_pkg::EDGE_RIGHT] ? lay : '0;
  assign lay_u = edges_q[afdtd_pkg::EDGE_UP]    ? lay : '0;
  assign lay_d = edges_q[afdtd_pkg::EDGE_DOWN]  ? lay : '0;
  assign cols  = GRID_W'(main_cols_q) + lay_l + lay_r + GRID_W'(2);
  assign rows  = GRID_W'(main_rows_q) + lay_u + lay_d + GRID_W'(2);
  assign skip_prod = 17'({cols, 2'b00}) * 17'(afdtd_pkg::SKIP_MUL);

  // depth into the enabled absorbing layers
  logic signed [9:0] cs, rs, ls, dl, dr, du, dd, kmax;

  always_comb begin
    cs = $signed({2'b00, cmd_i.col});
    rs = $signed({2'b00, cmd_i.row});
    ls = $signed({6'b0, layers_q});
    dl = ls + 10'sd1 - cs;
    dr = cs - $signed({4'b0, main_cols_q}) - (edges_q[afdtd_pkg::EDGE_LEFT] ? ls : 10'sd0);
    du = ls + 10'sd1 - rs;
    dd = rs - $signed({4'b0, main_rows_q}) - (edges_q[afdtd_pkg::EDGE_UP] ? ls : 10'sd0);
    kmax = 10'sd0;
    if (edges_q[afdtd_pkg::EDGE_LEFT] && dl > kmax) kmax = dl;
    if (edges_q[afdtd_pkg::EDGE_RIGHT] && dr > kmax) kmax = dr;
    if (edges_q[afdtd_pkg::EDGE_UP] && du > kmax) kmax = du;
    if (edges_q[afdtd_pkg::EDGE_DOWN] && dd > kmax) kmax = dd;
  end

  // stores
  logic [AW-1:0] idx, p_raddr, vx_raddr, vy_raddr;
  logic [31:0]   p_rd, vx_rd, vy_rd, wdata;
  logic signed [31:0] wv_q, res_q;

  assign idx = AW'(cmd_i.row * MAX_COLS + cmd_i.col);

  always_comb begin
    p_raddr  = idx;
    vx_raddr = idx;
    vy_raddr = idx;
    case (cmd_i.rd_phase)
      afdtd_pkg::RD_NEAR: begin
        p_raddr  = idx - AW'(1);
        vx_raddr = idx + AW'(1);
        vy_raddr = idx + AW'(MAX_COLS);
      end
      afdtd_pkg::RD_FAR: begin
        p_raddr = idx - AW'(MAX_COLS);
      end
      default: ;
    endcase
    case (cmd_i.wr_src)
      afdtd_pkg::WS_IN:   wdata = wv_q;
      afdtd_pkg::WS_ZERO: wdata = '0;
      default:            wdata = res_q;
    endcase
  end

  afdtd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_p_ram (
    .clk_i, .we_i(cmd_i.wr_p), .waddr_i(idx), .wdata_i(wdata),
    .re_i(cmd_i.rd_en), .raddr_i(p_raddr), .rdata_o(p_rd)
  );

  afdtd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vx_ram (
    .clk_i, .we_i(cmd_i.wr_vx), .waddr_i(idx), .wdata_i(wdata),
    .re_i(cmd_i.rd_en), .raddr_i(vx_raddr), .rdata_o(vx_rd)
  );

  afdtd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_vy_ram (
    .clk_i, .we_i(cmd_i.wr_vy), .waddr_i(idx), .wdata_i(wdata),
    .re_i(cmd_i.rd_en), .raddr_i(vy_raddr), .rdata_o(vy_rd)
  );

  // update arithmetic
  logic signed [31:0]       p0_q, p1_q, p2_q, vx0_q, vx1_q, vy0_q, vy1_q, v_q;
  logic [K_W-1:0]           k_q;
  logic signed [DIFF_W-1:0] d_q, d_new;
  logic [31:0]              coef_q;
  logic signed [ACC_W-1:0]  acc_q, t;
  logic [LO_W+31:0]         prod_lo;
  logic signed [HI_W-1:0]   dh;
  logic signed [HI_W+32:0]  prod_hi;
  logic signed [SUM_W-1:0]  x_full, x_clip;
  logic signed [X_W-1:0]    x_q;
  logic [X_W-1:0]           ax;
  logic [M_W-1:0]           m;
  logic [DND_W-1:0]         dnd_q, quo;
  logic [DVS_W-1:0]         dvs_q;
  logic                     neg_q, div_busy;
  logic [31:0]              sat;

  always_comb begin
    case (cmd_i.sel)
      afdtd_pkg::SEL_VX: d_new = DIFF_W'(p0_q) - DIFF_W'(p1_q);
      afdtd_pkg::SEL_VY: d_new = DIFF_W'(p0_q) - DIFF_W'(p2_q);
      default: d_new = DIFF_W'(vx1_q) - DIFF_W'(vx0_q) + DIFF_W'(vy1_q) - DIFF_W'(vy0_q);
    endcase
    prod_lo = d_q[LO_W-1:0] * coef_q;
    dh      = d_q[DIFF_W-1:LO_W];
    prod_hi = dh * $signed({1'b0, coef_q});
    t       = acc_q >>> afdtd_pkg::FRAC_W;
    x_full  = SUM_W'(v_q) - $signed(t[SUM_W-1:0]);
    if (x_full > afdtd_pkg::X_LIMIT) begin
      x_clip = afdtd_pkg::X_LIMIT;
    end else if (x_full < -afdtd_pkg::X_LIMIT) begin
      x_clip = -afdtd_pkg::X_LIMIT;
    end else begin
      x_clip = x_full;
    end
    ax = x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
    m  = (layers_q == 4'd0) ? M_W'(1) : {layers_q, 1'b0};
    // truncate toward zero, then saturate to 32 bits
    if (neg_q) begin
      sat = (quo > DND_W'(33'h080000000)) ? 32'h80000000 : 32'(-quo);
    end else begin
      sat = (quo > DND_W'(32'h7fffffff)) ? 32'h7fffffff : quo[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      wv_q <= in_data_i.write_value;
    end
    if (cmd_i.cap_center) begin
      p0_q  <= p_rd;
      vx0_q <= vx_rd;
      vy0_q <= vy_rd;
      k_q   <= kmax[K_W-1:0];
    end
    if (cmd_i.cap_near) begin
      p1_q  <= p_rd;
      vx1_q <= vx_rd;
      vy1_q <= vy_rd;
    end
    if (cmd_i.cap_far) begin
      p2_q <= p_rd;
    end
    case (cmd_i.op)
      afdtd_pkg::OP_LOAD: begin
        d_q    <= d_new;
        v_q    <= (cmd_i.sel == afdtd_pkg::SEL_VX) ? vx0_q :
                  (cmd_i.sel == afdtd_pkg::SEL_VY) ? vy0_q : p0_q;
        coef_q <= (cmd_i.sel == afdtd_pkg::SEL_P) ? pcoef_q : vcoef_q;
      end
      afdtd_pkg::OP_MLO:   acc_q <= ACC_W'($signed({1'b0, prod_lo}));
      afdtd_pkg::OP_MHI:   acc_q <= acc_q + (ACC_W'(prod_hi) <<< LO_W);
      afdtd_pkg::OP_SUB:   x_q   <= X_W'(x_clip);
      afdtd_pkg::OP_SCALE: begin
        neg_q <= x_q[X_W-1];
        dnd_q <= DND_W'(ax) * DND_W'(m);
        dvs_q <= DVS_W'(m) + DVS_W'(k_q);
      end
      afdtd_pkg::OP_SAT:   res_q <= sat;
      default: ;
    endcase
  end

  afdtd_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(dnd_q),
    .divisor_i(dvs_q), .busy_o(div_busy), .quotient_o(quo)
  );

  // result register
  afdtd_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.read_value <= cmd_i.out_rd ? p0_q : '0;
      out_q.status     <= cmd_i.out_status;
    end
  end

  assign out_data_o     = out_q;
  assign sts_o.oversize = ({2'b00, cols} > 9'(MAX_COLS)) || ({2'b00, rows} > 9'(MAX_ROWS));
  assign sts_o.cols     = cols;
  assign sts_o.rows     = rows;
  assign sts_o.skip_lim = skip_prod[afdtd_pkg::SKIP_SHIFT +: GRID_W];
  assign sts_o.div_busy = div_busy;

endmodule

FILE: rtl/core/afdtd_ctrl.sv
// controller: clearing sweep, item decode, cell loops and update sequencing
// depends on afdtd_pkg; drives afdtd_datapath through cmd_t
module afdtd_ctrl #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  afdtd_pkg::in_item_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  afdtd_pkg::sts_t     sts_i,
  output afdtd_pkg::cmd_t     cmd_o
);

  localparam int CNT_W = afdtd_pkg::CNT_W;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DECODE = 5'd2;
  localparam logic [4:0] S_RDWAIT = 5'd3;
  localparam logic [4:0] S_DONE   = 5'd4;
  localparam logic [4:0] S_CELL   = 5'd5;
  localparam logic [4:0] S_RD0    = 5'd6;
  localparam logic [4:0] S_RD1    = 5'd7;
  localparam logic [4:0] S_RD2    = 5'd8;
  localparam logic [4:0] S_RD3    = 5'd9;
  localparam logic [4:0] S_LOAD   = 5'd10;
  localparam logic [4:0] S_MLO    = 5'd11;
  localparam logic [4:0] S_MHI    = 5'd12;
  localparam logic [4:0] S_SUB    = 5'd13;
  localparam logic [4:0] S_SCALE  = 5'd14;
  localparam logic [4:0] S_DIV    = 5'd15;
  localparam logic [4:0] S_DWAIT  = 5'd16;
  localparam logic [4:0] S_SAT    = 5'd17;
  localparam logic [4:0] S_WB     = 5'd18;

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]       act_q, act_d, sel_q, sel_d, status_q, status_d;
  logic             pass_q, pass_d, rd_q, rd_d, out_valid_q, out_valid_d;
  logic [CNT_W-1:0] cols, rows;
  logic             accept;

  assign cols       = CNT_W'(sts_i.cols);
  assign rows       = CNT_W'(sts_i.rows);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    act_d       = act_q;
    sel_d       = sel_q;
    status_d    = status_q;
    pass_d      = pass_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.col      = col_q;
    cmd_o.row      = row_q;
    cmd_o.sel      = sel_q;
    cmd_o.rd_phase = afdtd_pkg::RD_CENTER;
    cmd_o.wr_src   = afdtd_pkg::WS_RES;
    cmd_o.take_in  = accept;
    case (state_q)
      S_CLEAR: begin
        // zero every entry of the three stores
        cmd_o.wr_p   = 1'b1;
        cmd_o.wr_vx  = 1'b1;
        cmd_o.wr_vy  = 1'b1;
        cmd_o.wr_src = afdtd_pkg::WS_ZERO;
        col_d = col_q + CNT_W'(1);
        if (col_q == CNT_W'(MAX_COLS - 1)) begin
          col_d = '0;
          row_d = row_q + CNT_W'(1);
          if (row_q == CNT_W'(MAX_ROWS - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          act_d   = in_data_i.action;
          col_d   = CNT_W'(in_data_i.cell_col);
          row_d   = CNT_W'(in_data_i.cell_row);
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        rd_d     = 1'b0;
        status_d = afdtd_pkg::ST_OK;
        state_d  = S_DONE;
        if (sts_i.oversize) begin
          status_d = afdtd_pkg::ST_OVERSIZE;
        end else begin
          case (act_q)
            afdtd_pkg::ACT_STEP: begin
              col_d   = CNT_W'(1);
              row_d   = CNT_W'(1);
              pass_d  = 1'b0;
              state_d = S_CELL;
            end
            afdtd_pkg::ACT_WRITE, afdtd_pkg::ACT_READ: begin
              if (col_q >= cols || row_q >= rows) begin
                status_d = afdtd_pkg::ST_OUTSIDE;
              end else if (act_q == afdtd_pkg::ACT_WRITE) begin
                cmd_o.wr_p   = 1'b1;
                cmd_o.wr_src = afdtd_pkg::WS_IN;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_RDWAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDWAIT: begin
        cmd_o.cap_center = 1'b1;
        rd_d    = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_rd     = rd_q;
          cmd_o.out_status = status_q;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_CELL: begin
        if (row_q >= rows - CNT_W'(1)) begin
          if (!pass_q) begin
            pass_d = 1'b1;
            col_d  = CNT_W'(1);
            row_d  = CNT_W'(1);
          end else begin
            rd_d     = 1'b0;
            status_d = afdtd_pkg::ST_OK;
            state_d  = S_DONE;
          end
        end else if (col_q >= cols - CNT_W'(1)) begin
          col_d = CNT_W'(1);
          row_d = row_q + CNT_W'(1);
        end else if (!pass_q && row_q == CNT_W'(1) && col_q < CNT_W'(sts_i.skip_lim)) begin
          // source row velocities stay untouched left of four fifths of the width
          col_d = col_q + CNT_W'(1);
        end else begin
          sel_d   = pass_q ? afdtd_pkg::SEL_P : afdtd_pkg::SEL_VX;
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RD1;
      end
      S_RD1: begin
        cmd_o.cap_center = 1'b1;
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_phase   = afdtd_pkg::RD_NEAR;
        state_d          = S_RD2;
      end
      S_RD2: begin
        cmd_o.cap_near = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_phase = afdtd_pkg::RD_FAR;
        state_d        = S_RD3;
      end
      S_RD3: begin
        cmd_o.cap_far = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.op = afdtd_pkg::OP_LOAD;
        state_d  = S_MLO;
      end
      S_MLO: begin
        cmd_o.op = afdtd_pkg::OP_MLO;
        state_d  = S_MHI;
      end
      S_MHI: begin
        cmd_o.op = afdtd_pkg::OP_MHI;
        state_d  = S_SUB;
      end
      S_SUB: begin
        cmd_o.op = afdtd_pkg::OP_SUB;
        state_d  = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.op = afdtd_pkg::OP_SCALE;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        cmd_o.op = afdtd_pkg::OP_SAT;
        state_d  = S_WB;
      end
      S_WB: begin
        cmd_o.wr_vx = (sel_q == afdtd_pkg::SEL_VX);
        cmd_o.wr_vy = (sel_q == afdtd_pkg::SEL_VY);
        cmd_o.wr_p  = (sel_q == afdtd_pkg::SEL_P);
        if (sel_q == afdtd_pkg::SEL_VX) begin
          sel_d   = afdtd_pkg::SEL_VY;
          state_d = S_LOAD;
        end else begin
          col_d   = col_q + CNT_W'(1);
          state_d = S_CELL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      act_q       <= afdtd_pkg::ACT_STEP;
      sel_q       <= afdtd_pkg::SEL_VX;
      status_q    <= afdtd_pkg::ST_OK;
      pass_q      <= 1'b0;
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      act_q       <= act_d;
      sel_q       <= sel_d;
      status_q    <= status_d;
      pass_q      <= pass_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still waiting");

  // divider is started only when idle and read only after it finished
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == afdtd_pkg::OP_SAT) |-> !sts_i.div_busy)
    else $error("quotient taken before the divider finished");

  // an accepted transaction is decoded in the next cycle
  a_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DECODE))
    else $error("accepted transaction not decoded");

endmodule

FILE: bench/testbench.sv
// self-checking bench for acoustic_fdtd2d_pml_step: a directed table, then random phases
// depends on afdtd_pkg and the rtl under rtl/core; keeps its own fixed-point grid model
`timescale 1ns / 1ps

module testbench;
  import afdtd_pkg::*;

  localparam int GRID_MAX_COLS = 64;
  localparam int GRID_MAX_ROWS = 64;
  localparam int GRID_CELLS    = GRID_MAX_COLS * GRID_MAX_ROWS;
  // worst single transaction here is a step on a 19 by 19 grid
  localparam int STALL_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 25;  // per idling phase, four phases

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = CFG_MAIN_COLS;
  logic [31:0] cfg_data_i = '0;

  acoustic_fdtd2d_pml_step #(
    .MAX_COLS(GRID_MAX_COLS),
    .MAX_ROWS(GRID_MAX_ROWS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // grid model: configuration copy and the three stores
  // ---------------------------------------------------------------------------
  logic [5:0]  m_main_cols = RST_MAIN_COLS;
  logic [5:0]  m_main_rows = RST_MAIN_ROWS;
  logic [3:0]  m_layers    = RST_PML_LAYERS;
  logic [3:0]  m_edges     = RST_PML_EDGES;
  logic [31:0] m_vel_coef  = RST_VEL_COEF;
  logic [31:0] m_prs_coef  = RST_PRS_COEF;
  logic signed [31:0] m_press [GRID_CELLS];
  logic signed [31:0] m_vel_x [GRID_CELLS];
  logic signed [31:0] m_vel_y [GRID_CELLS];

  // grid size including absorbing layers and the one-cell border
  function automatic int grid_cols();
    return int'(m_main_cols) + int'(m_layers) * m_edges[EDGE_LEFT]
         + int'(m_layers) * m_edges[EDGE_RIGHT] + 2;
  endfunction

  function automatic int grid_rows();
    return int'(m_main_rows) + int'(m_layers) * m_edges[EDGE_UP]
         + int'(m_layers) * m_edges[EDGE_DOWN] + 2;
  endfunction

  // deepest penetration into any enabled absorbing layer
  function automatic longint layer_depth(longint c, longint r);
    longint lay;
    longint k;
    longint lf;
    longint uf;
    lay = longint'(m_layers);
    lf = longint'(m_edges[EDGE_LEFT]);
    uf = longint'(m_edges[EDGE_UP]);
    k = 0;
    if (m_edges[EDGE_LEFT] && (lay + 1 - c) > k) k = lay + 1 - c;
    if (m_edges[EDGE_RIGHT] &&
        (c - longint'(m_main_cols) - lay * lf) > k)
      k = c - longint'(m_main_cols) - lay * lf;
    if (m_edges[EDGE_UP] && (lay + 1 - r) > k) k = lay + 1 - r;
    if (m_edges[EDGE_DOWN] &&
        (r - longint'(m_main_rows) - lay * uf) > k)
      k = r - longint'(m_main_rows) - lay * uf;
    return k;
  endfunction

  function automatic logic signed [31:0] clip32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // multiply by 2L/(2L+k), truncating toward zero, then saturate
  function automatic logic signed [31:0] absorb(longint x, longint k);
    longint two_l;
    two_l = 2 * longint'(m_layers);
    if (two_l == 0 || k == 0) return clip32(x);
    return clip32((x * two_l) / (two_l + k));
  endfunction

  // floor(d * coef / 2^20), split so the product stays inside 64 bits
  function automatic longint coef_scale(longint d, logic [31:0] coef);
    longint hi;
    longint lo;
    hi = d * longint'({32'd0, coef >> FRAC_W});
    lo = d * longint'({44'd0, coef[FRAC_W-1:0]});
    return hi + (lo >>> FRAC_W);
  endfunction

  function automatic void advance_grid(int cols, int rows);
    int idx;
    longint k;
    longint dx;
    longint dy;
    longint dv;
    // velocity pass, top interior row skipped over its first four fifths
    for (int r = 1; r < rows - 1; r++) begin
      for (int c = 1; c < cols - 1; c++) begin
        if (r == 1 && c < (cols * 4) / 5) continue;
        idx = r * GRID_MAX_COLS + c;
        k = layer_depth(c, r);
        dx = longint'(m_press[idx]) - longint'(m_press[idx-1]);
        dy = longint'(m_press[idx]) - longint'(m_press[idx-GRID_MAX_COLS]);
        m_vel_x[idx] = absorb(longint'(m_vel_x[idx]) - coef_scale(dx, m_vel_coef), k);
        m_vel_y[idx] = absorb(longint'(m_vel_y[idx]) - coef_scale(dy, m_vel_coef), k);
      end
    end
    // pressure pass from the velocity divergence
    for (int r = 1; r < rows - 1; r++) begin
      for (int c = 1; c < cols - 1; c++) begin
        idx = r * GRID_MAX_COLS + c;
        dv = longint'(m_vel_x[idx+1]) - longint'(m_vel_x[idx])
           + longint'(m_vel_y[idx+GRID_MAX_COLS]) - longint'(m_vel_y[idx]);
        m_press[idx] = absorb(longint'(m_press[idx]) - coef_scale(dv, m_prs_coef),
                              layer_depth(c, r));
      end
    end
  endfunction

  // applies one transaction to the model and returns the answer it should give
  function automatic out_item_t apply_transaction(in_item_t it);
    out_item_t res;
    int cols;
    int rows;
    int idx;
    res = '0;
    cols = grid_cols();
    rows = grid_rows();
    idx = int'(it.cell_row) * GRID_MAX_COLS + int'(it.cell_col);
    if (cols > GRID_MAX_COLS || rows > GRID_MAX_ROWS) begin
      res.status = ST_OVERSIZE;
    end else if (it.action == ACT_STEP) begin
      advance_grid(cols, rows);
    end else if (it.action == ACT_WRITE || it.action == ACT_READ) begin
      if (int'(it.cell_col) >= cols || int'(it.cell_row) >= rows) begin
        res.status = ST_OUTSIDE;
      end else if (it.action == ACT_WRITE) begin
        m_press[idx] = it.write_value;
      end else begin
        res.read_value = m_press[idx];
      end
    end
    return res;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [31:0] val);
    case (idx)
      CFG_MAIN_COLS:  m_main_cols = val[5:0];
      CFG_MAIN_ROWS:  m_main_rows = val[5:0];
      CFG_PML_LAYERS: m_layers    = val[3:0];
      CFG_PML_EDGES:  m_edges     = val[3:0];
      CFG_VEL_COEF:   m_vel_coef  = val;
      CFG_PRS_COEF:   m_prs_coef  = val;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // expected answers, checker and watchdog
  // ---------------------------------------------------------------------------
  out_item_t pending_answers[$];
  int error_count = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result read_value=%h status=%0d",
                 $time, out_data_o.read_value, out_data_o.status);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_data_o.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h",
                   $time, want.read_value, out_data_o.read_value);
          error_count++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_data_o.status);
          error_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);

    // cycles with no transaction on either data channel
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, all called just after a rising edge
  // ---------------------------------------------------------------------------
  // valid is only dropped inside an idle gap or by wait_drained, so back-to-back items keep it high
  task automatic send_transaction(in_item_t it, bit typed, out_item_t typed_ans);
    out_item_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_transaction(it);
    pending_answers.push_back(typed ? typed_ans : predicted);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // caller lowers cfg_valid_i after the last write of a batch
  task automatic write_register(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_config(idx, val);
  endtask

  task automatic write_all_registers(logic [5:0] mc, logic [5:0] mr, logic [3:0] lay,
                                     logic [3:0] edg, logic [31:0] vc, logic [31:0] pc);
    wait_drained();
    write_register(CFG_MAIN_COLS, {26'd0, mc});
    write_register(CFG_MAIN_ROWS, {26'd0, mr});
    write_register(CFG_PML_LAYERS, {28'd0, lay});
    write_register(CFG_PML_EDGES, {28'd0, edg});
    write_register(CFG_VEL_COEF, vc);
    write_register(CFG_PRS_COEF, pc);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    in_item_t    item;
    bit          typed;
    out_item_t   answer;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void plan_cfg(logic [2:0] idx, logic [31:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endfunction

  // typed answer is given only where it is obvious; otherwise the model decides
  function automatic void plan_item(logic [1:0] act, int col, int row, logic [31:0] val,
                                    bit typed = 0, logic [31:0] rv = 0,
                                    logic [1:0] st = ST_OK);
    plan_row_t r;
    r = '{default: '0};
    r.item.action = act;
    r.item.cell_col = col[5:0];
    r.item.cell_row = row[5:0];
    r.item.write_value = val;
    r.typed = typed;
    r.answer.read_value = rv;
    r.answer.status = st;
    plan.push_back(r);
  endfunction

  function automatic void build_plan();
    // reset grid is 54 by 54, stores cleared
    plan_item(ACT_READ, 0, 0, 0, 1, 0, ST_OK);
    plan_item(ACT_READ, 53, 53, 0, 1, 0, ST_OK);
    plan_item(ACT_READ, 54, 0, 0, 1, 0, ST_OUTSIDE);
    plan_item(ACT_WRITE, 0, 54, 32'h7fffffff, 1, 0, ST_OUTSIDE);
    plan_item(ACT_WRITE, 63, 63, 32'hffffffff, 1, 0, ST_OUTSIDE);
    plan_item(2'd3, 5, 5, 32'h12345678, 1, 0, ST_OK);  // unused action
    // 8 by 7 grid, single layer on every edge
    plan_cfg(CFG_MAIN_COLS, 4);
    plan_cfg(CFG_MAIN_ROWS, 3);
    plan_cfg(CFG_PML_LAYERS, 1);
    plan_item(ACT_WRITE, 3, 3, 32'h7fffffff, 1, 0, ST_OK);
    plan_item(ACT_WRITE, 4, 3, 32'h80000000, 1, 0, ST_OK);
    plan_item(ACT_WRITE, 6, 1, 32'h00010000, 1, 0, ST_OK);
    plan_item(ACT_STEP, 0, 0, 0);
    plan_item(ACT_READ, 3, 3, 0);
    plan_item(ACT_READ, 4, 3, 0);
    plan_item(ACT_READ, 7, 6, 0, 1, 0, ST_OK);  // border cell never updated
    plan_item(ACT_READ, 8, 0, 0, 1, 0, ST_OUTSIDE);
    // largest coefficients drive everything into saturation
    plan_cfg(CFG_VEL_COEF, 32'hffffffff);
    plan_cfg(CFG_PRS_COEF, 32'hffffffff);
    plan_item(ACT_STEP, 0, 0, 0);
    plan_item(ACT_READ, 3, 3, 0);
    // no layers: undamped update
    plan_cfg(CFG_PML_LAYERS, 0);
    plan_cfg(CFG_PML_EDGES, 0);
    plan_item(ACT_STEP, 0, 0, 0);
    plan_item(ACT_READ, 3, 2, 0);
    // oversized grid rejects everything
    plan_cfg(CFG_MAIN_COLS, 62);
    plan_cfg(CFG_PML_LAYERS, 8);
    plan_cfg(CFG_PML_EDGES, 15);
    plan_item(ACT_READ, 0, 0, 0, 1, 0, ST_OVERSIZE);
    plan_item(ACT_STEP, 0, 0, 0, 1, 0, ST_OVERSIZE);
    plan_item(ACT_WRITE, 1, 1, 32'h1, 1, 0, ST_OVERSIZE);
    // thickest layers around a one-cell main region, 19 by 19
    plan_cfg(CFG_MAIN_COLS, 1);
    plan_cfg(CFG_MAIN_ROWS, 1);
    plan_cfg(CFG_VEL_COEF, 32'h00100000);
    plan_cfg(CFG_PRS_COEF, 0);
    plan_item(ACT_WRITE, 9, 9, 32'h00400000, 1, 0, ST_OK);
    plan_item(ACT_STEP, 0, 0, 0);
    plan_item(ACT_READ, 9, 9, 0);
  endfunction

  // ---------------------------------------------------------------------------
  // random phases
  // ---------------------------------------------------------------------------
  // mostly writes, reads and (except on the wide grid) steps inside the grid; some out-of-grid and unused
  task automatic random_phase(bit wide_grid);
    in_item_t it;
    int roll;
    int cols;
    int rows;
    if (wide_grid)
      // exactly fills the store, steps would be far too slow here
      write_all_registers(62, 62, 4'($urandom_range(0, 8)), 0, $urandom, $urandom);
    else
      write_all_registers(6'($urandom_range(0, 5)), 6'($urandom_range(0, 5)),
                          4'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                          ($urandom_range(3) == 0) ? 32'd0 : $urandom,
                          ($urandom_range(3) == 0) ? 32'hffffffff : $urandom);
    cols = grid_cols();
    rows = grid_rows();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(99);
      it.cell_col = 6'($urandom_range(0, cols - 1));
      it.cell_row = 6'($urandom_range(0, rows - 1));
      it.write_value = ($urandom_range(1) == 0) ? $urandom
                                                 : 32'($signed($urandom_range(0, 20'hfffff)));
      if (roll < 40) begin
        it.action = ACT_WRITE;
      end else if (roll < 72) begin
        it.action = ACT_READ;
      end else if (roll < 88) begin
        it.action = wide_grid ? ACT_READ : ACT_STEP;
      end else if (roll < 96) begin
        it.action = 2'($urandom_range(ACT_WRITE, ACT_READ));
        it.cell_col = 6'($urandom_range(0, 63));
        it.cell_row = 6'($urandom_range(0, 63));
      end else begin
        it.action = 2'd3;
      end
      send_transaction(it, 1'b0, '0);
      // hold off until the block has answered everything
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  initial begin
    plan_row_t r;
    int idle_pct[4][2];
    idle_pct = '{'{0, 0}, '{47, 0}, '{0, 47}, '{23, 23}};
    for (int i = 0; i < GRID_CELLS; i++) begin
      m_press[i] = '0;
      m_vel_x[i] = '0;
      m_vel_y[i] = '0;
    end
    build_plan();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_cfg) begin
        wait_drained();
        write_register(r.reg_idx, r.reg_val);
        cfg_valid_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        send_transaction(r.item, r.typed, r.answer);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct = idle_pct[ph][0];
      rcv_stall_pct = idle_pct[ph][1];
      random_phase(ph == 2);
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
